### rtl/rrc_pkg.sv
// Shared constants, types and codes for the RTP receive classifier.
`timescale 1ns / 1ps

package rrc_pkg;

    localparam int PT_W     = 7;
    localparam int TS_W     = 32;
    localparam int EV_W     = 8;
    localparam int VOL_W    = 6;
    localparam int DIV_W    = 16;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 2;
    localparam int IN_W     = 88;
    localparam int OUT_W    = 88;

    // Divider runs one quotient bit per cycle.
    localparam int DIV_STEPS = TS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_MEDIA      = 3'd0;
    localparam status_t ST_DTMF_KEY   = 3'd1;
    localparam status_t ST_DTMF_IGN   = 3'd2;
    localparam status_t ST_TYPE_CHG   = 3'd3;
    localparam status_t ST_REJECT     = 3'd4;
    localparam status_t ST_PARSE_FAIL = 3'd5;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_MEDIA_PT = 2'd0;
    localparam reg_idx_t REG_DTMF_PT  = 2'd1;
    localparam reg_idx_t REG_MAX_JUMP = 2'd2;
    localparam reg_idx_t REG_DIVISOR  = 2'd3;

    localparam logic [PT_W-1:0]  MEDIA_PT_RST = 7'd0;
    localparam logic [PT_W-1:0]  DTMF_PT_RST  = 7'd101;
    localparam logic [TS_W-1:0]  MAX_JUMP_RST = 32'd160000;
    localparam logic [DIV_W-1:0] DIVISOR_RST  = 16'd8;

    localparam logic [EV_W-1:0] NO_EVENT = 8'd255;
    localparam logic [7:0]      NO_TYPE  = 8'd255;

    typedef struct packed {
        logic             start;
        logic [TS_W-1:0]  num;
        logic [DIV_W-1:0] den;
    } div_req_t;

endpackage

### rtl/rrc_div.sv
// Restoring divider, one quotient bit per cycle; a zero divisor yields all ones.
`timescale 1ns / 1ps

module rrc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrc_pkg::div_req_t             req,
    output logic                          done,
    output logic [rrc_pkg::TS_W-1:0]      quot
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [rrc_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [rrc_pkg::TS_W-1:0]        q_reg, q_next;
    logic [rrc_pkg::DIV_W-1:0]       rem_reg, rem_next;
    logic [rrc_pkg::DIV_W-1:0]       den_reg, den_next;
    logic [rrc_pkg::DIV_W:0]         trial;
    logic [rrc_pkg::DIV_W:0]         diff;
    logic                            ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[rrc_pkg::TS_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            // numerator bits shift out the top while quotient bits enter at the bottom
            rem_next = ge ? diff[rrc_pkg::DIV_W-1:0] : trial[rrc_pkg::DIV_W-1:0];
            q_next   = {q_reg[rrc_pkg::TS_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rrc_pkg::DIV_CNT_W'(rrc_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### rtl/rtp_receive_classifier_unit.sv
// Top level: RTP receive classifier with media timing and telephone-event handling.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   s_tuser: parse_ok; s_tdata: header fields
// m_*       out        m_tvalid/m_tready   m_tuser: status; m_tdata: result fields
// cfg_*     in         cfg_we              cfg_addr selects register, cfg_data value
//
// A media beat passes through accept, classify, 32 divider steps, divider done and finish;
// other beats pass through accept, classify and finish only. The bit-serial divider sets the media beat's length.
// s_tready is high only while idle; a finished result waits in the output register
// while the next beat is taken. Reset is asynchronous, active low.

module rtp_receive_classifier_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [6:0] payload_type, [38:7] timestamp, [46:39] dtmf_event, [47] dtmf_end,
    // [53:48] dtmf_volume, [85:54] sync_time_ms, [87:86] zero
    input  logic [rrc_pkg::IN_W-1:0]         s_tdata,
    // [0] parse_ok
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] resynced, [32:1] gen_time, [40:33] dtmf_key, [46:41] dtmf_level,
    // [53:47] new_payload_type, [85:54] received_count, [87:86] zero
    output logic [rrc_pkg::OUT_W-1:0]        m_tdata,
    // [2:0] status
    output logic [rrc_pkg::STATUS_W-1:0]     m_tuser,
    input  logic                             cfg_we,
    input  logic [rrc_pkg::IDX_W-1:0]        cfg_addr,
    input  logic [rrc_pkg::TS_W-1:0]         cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_CLASSIFY, S_DIVIDE, S_FINISH} state_t;

    state_t                          state_reg;

    logic [rrc_pkg::PT_W-1:0]        media_pt_reg;
    logic [rrc_pkg::PT_W-1:0]        dtmf_pt_reg;
    logic [rrc_pkg::TS_W-1:0]        max_jump_reg;
    logic [rrc_pkg::DIV_W-1:0]       divisor_reg;

    logic [rrc_pkg::TS_W-1:0]        first_ts_reg;
    logic [rrc_pkg::TS_W-1:0]        first_time_reg;
    logic [rrc_pkg::EV_W-1:0]        last_event_reg;
    logic [7:0]                      last_pt_reg;
    logic [rrc_pkg::TS_W-1:0]        count_reg;

    logic                            in_ok_reg;
    logic [rrc_pkg::PT_W-1:0]        in_pt_reg;
    logic [rrc_pkg::TS_W-1:0]        in_ts_reg;
    logic [rrc_pkg::EV_W-1:0]        in_ev_reg;
    logic                            in_end_reg;
    logic [rrc_pkg::VOL_W-1:0]       in_vol_reg;
    logic [rrc_pkg::TS_W-1:0]        in_sync_reg;

    rrc_pkg::status_t                res_status_reg;
    logic                            res_resync_reg;
    logic [rrc_pkg::EV_W-1:0]        res_key_reg;
    logic [rrc_pkg::VOL_W-1:0]       res_level_reg;
    logic [rrc_pkg::PT_W-1:0]        res_newpt_reg;

    logic                            m_valid_reg;
    rrc_pkg::status_t                m_status_reg;
    logic                            m_resync_reg;
    logic [rrc_pkg::TS_W-1:0]        m_gen_reg;
    logic [rrc_pkg::EV_W-1:0]        m_key_reg;
    logic [rrc_pkg::VOL_W-1:0]       m_level_reg;
    logic [rrc_pkg::PT_W-1:0]        m_newpt_reg;
    logic [rrc_pkg::TS_W-1:0]        m_count_reg;

    logic                            in_beat;
    logic                            is_media;
    logic                            is_dtmf;
    logic [rrc_pkg::TS_W-1:0]        ts_dist;
    logic                            need_resync;
    logic                            out_free;
    rrc_pkg::div_req_t               div_req;
    logic                            div_done;
    logic [rrc_pkg::TS_W-1:0]        div_quot;

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    assign is_media    = (in_pt_reg == media_pt_reg);
    assign is_dtmf     = (in_pt_reg == dtmf_pt_reg);
    assign ts_dist     = in_ts_reg - first_ts_reg;
    assign need_resync = (first_ts_reg == '0) || (ts_dist > max_jump_reg);
    assign out_free    = !m_valid_reg || m_tready;

    always_comb
    begin
        div_req.start = (state_reg == S_CLASSIFY) && in_ok_reg && is_media;
        div_req.num   = need_resync ? '0 : ts_dist;
        div_req.den   = divisor_reg;
    end

    rrc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            media_pt_reg <= rrc_pkg::MEDIA_PT_RST;
            dtmf_pt_reg  <= rrc_pkg::DTMF_PT_RST;
            max_jump_reg <= rrc_pkg::MAX_JUMP_RST;
            divisor_reg  <= rrc_pkg::DIVISOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rrc_pkg::REG_MEDIA_PT: media_pt_reg <= cfg_data[rrc_pkg::PT_W-1:0];
                rrc_pkg::REG_DTMF_PT:  dtmf_pt_reg  <= cfg_data[rrc_pkg::PT_W-1:0];
                rrc_pkg::REG_MAX_JUMP: max_jump_reg <= cfg_data;
                rrc_pkg::REG_DIVISOR:  divisor_reg  <= cfg_data[rrc_pkg::DIV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_ok_reg   <= s_tuser;
            in_pt_reg   <= s_tdata[6:0];
            in_ts_reg   <= s_tdata[38:7];
            in_ev_reg   <= s_tdata[46:39];
            in_end_reg  <= s_tdata[47];
            in_vol_reg  <= s_tdata[53:48];
            in_sync_reg <= s_tdata[85:54];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_ts_reg   <= '0;
            first_time_reg <= '0;
            last_event_reg <= rrc_pkg::NO_EVENT;
            last_pt_reg    <= rrc_pkg::NO_TYPE;
            count_reg      <= '0;
            res_status_reg <= rrc_pkg::ST_PARSE_FAIL;
            res_resync_reg <= 1'b0;
            res_key_reg    <= '0;
            res_level_reg  <= '0;
            res_newpt_reg  <= '0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= rrc_pkg::ST_PARSE_FAIL;
            m_resync_reg   <= 1'b0;
            m_gen_reg      <= '0;
            m_key_reg      <= '0;
            m_level_reg    <= '0;
            m_newpt_reg    <= '0;
            m_count_reg    <= '0;
        end
        else
        begin
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= S_CLASSIFY;
                    end
                end

                S_CLASSIFY:
                begin
                    res_resync_reg <= 1'b0;
                    res_key_reg    <= '0;
                    res_level_reg  <= '0;
                    res_newpt_reg  <= '0;
                    state_reg      <= S_FINISH;
                    if (!in_ok_reg)
                    begin
                        res_status_reg <= rrc_pkg::ST_PARSE_FAIL;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (is_media)
                        begin
                            last_pt_reg    <= {1'b0, in_pt_reg};
                            res_status_reg <= rrc_pkg::ST_MEDIA;
                            state_reg      <= S_DIVIDE;
                            if (need_resync)
                            begin
                                first_ts_reg   <= in_ts_reg;
                                first_time_reg <= in_sync_reg;
                                res_resync_reg <= 1'b1;
                            end
                        end
                        else if (is_dtmf)
                        begin
                            if (in_ev_reg != last_event_reg && !in_end_reg)
                            begin
                                last_event_reg <= in_ev_reg;
                                res_key_reg    <= in_ev_reg;
                                res_level_reg  <= in_vol_reg;
                                res_status_reg <= rrc_pkg::ST_DTMF_KEY;
                            end
                            else
                            begin
                                if (in_end_reg)
                                begin
                                    last_event_reg <= rrc_pkg::NO_EVENT;
                                end
                                res_status_reg <= rrc_pkg::ST_DTMF_IGN;
                            end
                        end
                        else if (last_pt_reg != {1'b0, in_pt_reg})
                        begin
                            last_pt_reg    <= {1'b0, in_pt_reg};
                            res_newpt_reg  <= in_pt_reg;
                            res_status_reg <= rrc_pkg::ST_TYPE_CHG;
                        end
                        else
                        begin
                            res_status_reg <= rrc_pkg::ST_REJECT;
                        end
                    end
                end

                S_DIVIDE:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_resync_reg <= res_resync_reg;
                        m_gen_reg    <= (res_status_reg == rrc_pkg::ST_MEDIA) ?
                                        div_quot + first_time_reg : '0;
                        m_key_reg    <= res_key_reg;
                        m_level_reg  <= res_level_reg;
                        m_newpt_reg  <= res_newpt_reg;
                        m_count_reg  <= count_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_count_reg, m_newpt_reg, m_level_reg,
                       m_key_reg, m_gen_reg, m_resync_reg};

endmodule
